### rtl/psdw_pkg.sv
package psdw_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    // A chunk never exceeds one page, so it fits in one bit more than an offset.
    localparam int ROOM_W     = PAGE_BITS + 1;

    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LINES      = 3'd0,
        REG_BYTES      = 3'd1,
        REG_MEM_START  = 3'd2,
        REG_FB_START   = 3'd3,
        REG_MEM_STRIDE = 3'd4,
        REG_FB_STRIDE  = 3'd5
    } psdw_reg_t;

    typedef struct packed {
        logic [15:0] lines_in_transfer;
        logic [23:0] bytes_per_line;
        logic [31:0] memory_start_offset;
        logic [31:0] framebuffer_start;
        logic [23:0] memory_line_stride;
        logic [31:0] framebuffer_line_stride;
    } psdw_cfg_t;

    typedef struct packed {
        logic [19:0] page_index;
        logic [11:0] page_offset;
        logic [31:0] device_address;
        logic [12:0] chunk_bytes;
        logic [31:0] descriptor_number;
        logic        final_chunk;
        logic        chunk_valid;
    } psdw_desc_t;

endpackage

### rtl/psdw_regs.sv
module psdw_regs
    import psdw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output psdw_cfg_t             cfg
);

    psdw_cfg_t cfg_reg;
    psdw_cfg_t cfg_next;
    psdw_reg_t reg_sel;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_sel = psdw_reg_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_LINES:      cfg_next.lines_in_transfer       = pwdata[15:0];
                REG_BYTES:      cfg_next.bytes_per_line          = pwdata[23:0];
                REG_MEM_START:  cfg_next.memory_start_offset     = pwdata;
                REG_FB_START:   cfg_next.framebuffer_start       = pwdata;
                REG_MEM_STRIDE: cfg_next.memory_line_stride      = pwdata[23:0];
                REG_FB_STRIDE:  cfg_next.framebuffer_line_stride = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_LINES:      prdata = 32'(cfg_reg.lines_in_transfer);
            REG_BYTES:      prdata = 32'(cfg_reg.bytes_per_line);
            REG_MEM_START:  prdata = cfg_reg.memory_start_offset;
            REG_FB_START:   prdata = cfg_reg.framebuffer_start;
            REG_MEM_STRIDE: prdata = 32'(cfg_reg.memory_line_stride);
            REG_FB_STRIDE:  prdata = cfg_reg.framebuffer_line_stride;
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/psdw_core.sv
module psdw_core
    import psdw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       restart,
    input  psdw_cfg_t  cfg,
    output psdw_desc_t desc
);

    logic        walk_active_reg, walk_active_next;
    logic [15:0] lines_done_reg, lines_done_next;
    logic [23:0] line_left_reg, line_left_next;
    logic [31:0] mem_cursor_reg, mem_cursor_next;
    logic [31:0] dev_cursor_reg, dev_cursor_next;
    logic [31:0] mem_base_reg, mem_base_next;
    logic [31:0] dev_base_reg, dev_base_next;
    logic [31:0] desc_count_reg, desc_count_next;

    // Effective state once a restart has reloaded the walk.
    logic              act_e;
    logic [15:0]       lines_e;
    logic [23:0]       left_e;
    logic [31:0]       mc_e, dc_e, mb_e, db_e, cnt_e;
    logic [ROOM_W-1:0] room;
    logic [ROOM_W-1:0] chunk;
    logic [23:0]       left_after;
    logic [15:0]       lines_inc;
    logic              line_end;
    logic              walk_end;

    always_comb begin
        if (restart) begin
            act_e   = (cfg.lines_in_transfer != 16'd0) && (cfg.bytes_per_line != 24'd0);
            lines_e = 16'd0;
            left_e  = cfg.bytes_per_line;
            mc_e    = cfg.memory_start_offset;
            dc_e    = cfg.framebuffer_start;
            mb_e    = cfg.memory_start_offset;
            db_e    = cfg.framebuffer_start;
            cnt_e   = 32'd0;
        end else begin
            act_e   = walk_active_reg;
            lines_e = lines_done_reg;
            left_e  = line_left_reg;
            mc_e    = mem_cursor_reg;
            dc_e    = dev_cursor_reg;
            mb_e    = mem_base_reg;
            db_e    = dev_base_reg;
            cnt_e   = desc_count_reg;
        end
    end

    always_comb begin
        room       = ROOM_W'(PAGE_BYTES) - ROOM_W'(mc_e[PAGE_BITS-1:0]);
        chunk      = (left_e < 24'(room)) ? left_e[ROOM_W-1:0] : room;
        left_after = left_e - 24'(chunk);
        lines_inc  = lines_e + 16'd1;
        line_end   = (left_after == 24'd0);
        walk_end   = line_end && ((lines_inc == 16'd0) ||
                                  (lines_inc >= cfg.lines_in_transfer) ||
                                  (cfg.bytes_per_line == 24'd0));
    end

    always_comb begin
        walk_active_next = act_e;
        lines_done_next  = lines_e;
        line_left_next   = left_e;
        mem_cursor_next  = mc_e;
        dev_cursor_next  = dc_e;
        mem_base_next    = mb_e;
        dev_base_next    = db_e;
        desc_count_next  = cnt_e;
        desc             = '0;
        if (act_e) begin
            desc.page_index        = 20'(mc_e >> PAGE_BITS);
            desc.page_offset       = 12'(mc_e[PAGE_BITS-1:0]);
            desc.device_address    = dc_e;
            desc.chunk_bytes       = 13'(chunk);
            desc.descriptor_number = cnt_e;
            desc.final_chunk       = walk_end;
            desc.chunk_valid       = 1'b1;

            desc_count_next = cnt_e + 32'd1;
            line_left_next  = left_after;
            mem_cursor_next = mc_e + 32'(chunk);
            dev_cursor_next = dc_e + 32'(chunk);
            if (line_end) begin
                lines_done_next = lines_inc;
                if (walk_end) begin
                    walk_active_next = 1'b0;
                end else begin
                    mem_base_next   = mb_e + 32'(cfg.memory_line_stride);
                    dev_base_next   = db_e + cfg.framebuffer_line_stride;
                    mem_cursor_next = mb_e + 32'(cfg.memory_line_stride);
                    dev_cursor_next = db_e + cfg.framebuffer_line_stride;
                    line_left_next  = cfg.bytes_per_line;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_active_reg <= 1'b0;
            lines_done_reg  <= '0;
            line_left_reg   <= '0;
            mem_cursor_reg  <= '0;
            dev_cursor_reg  <= '0;
            mem_base_reg    <= '0;
            dev_base_reg    <= '0;
            desc_count_reg  <= '0;
        end else if (step) begin
            walk_active_reg <= walk_active_next;
            lines_done_reg  <= lines_done_next;
            line_left_reg   <= line_left_next;
            mem_cursor_reg  <= mem_cursor_next;
            dev_cursor_reg  <= dev_cursor_next;
            mem_base_reg    <= mem_base_next;
            dev_base_reg    <= dev_base_next;
            desc_count_reg  <= desc_count_next;
        end
    end

endmodule

### rtl/page_split_dma_descriptor_walker.sv
// A request waits in the request register until the result register is free or its
// descriptor is taken; then the walk steps and the descriptor reaches the m_ ports.
// Throughput: one descriptor per cycle while m_ready is high, set by the cursor update
// between the request register and the descriptor register.
// Reset: synchronous, active low; clears the configuration, the walk state and both
// valid flags, so no walk is active and no transaction is held.
module page_split_dma_descriptor_walker
    import psdw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_restart,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [19:0]           m_page_index,
    output logic [11:0]           m_page_offset,
    output logic [31:0]           m_device_address,
    output logic [12:0]           m_chunk_bytes,
    output logic [31:0]           m_descriptor_number,
    output logic                  m_final_chunk,
    output logic                  m_chunk_valid
);

    psdw_cfg_t  cfg;
    psdw_desc_t desc;
    psdw_desc_t out_reg;
    logic       in_valid_reg;
    logic       restart_reg;
    logic       out_valid_reg;
    logic       move;

    psdw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The walk advances only when the held request moves into the result register.
    assign move    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || move;

    psdw_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (move),
        .restart (restart_reg),
        .cfg     (cfg),
        .desc    (desc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (move) begin
                in_valid_reg <= 1'b0;
            end
            if (move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            restart_reg <= s_restart;
        end
        if (move) begin
            out_reg <= desc;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_page_index        = out_reg.page_index;
    assign m_page_offset       = out_reg.page_offset;
    assign m_device_address    = out_reg.device_address;
    assign m_chunk_bytes       = out_reg.chunk_bytes;
    assign m_descriptor_number = out_reg.descriptor_number;
    assign m_final_chunk       = out_reg.final_chunk;
    assign m_chunk_valid       = out_reg.chunk_valid;

    a_empty_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_chunk_valid) |-> (m_chunk_bytes == 13'd0 &&
            m_descriptor_number == 32'd0 && !m_final_chunk))
        else $error("descriptor marked not valid carries non-zero fields");

    a_chunk_in_page: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_chunk_valid) |-> (m_chunk_bytes != 13'd0 &&
            (32'(m_page_offset) + 32'(m_chunk_bytes)) <= 32'(PAGE_BYTES)))
        else $error("chunk is empty or crosses a page boundary");

    a_move_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        move |=> m_valid)
        else $error("processed transaction did not reach the result register");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_descriptor_number) || $past(move)))
        else $error("waiting descriptor was overwritten");

endmodule

### verif/testbench.sv
module testbench;
    import psdw_pkg::*;

    // Holds a copy of the walker's registers and walk state. It works out the
    // descriptor that each accepted request should yield and queues it.
    class descriptor_tracker;
        psdw_cfg_t   geometry;
        bit          walk_active;
        logic [15:0] lines_done;
        logic [23:0] line_bytes_left;
        logic [31:0] memory_cursor;
        logic [31:0] device_cursor;
        logic [31:0] memory_line_base;
        logic [31:0] device_line_base;
        logic [31:0] next_number;
        psdw_desc_t  pending[$];
        int          mismatches;

        function new();
            geometry         = '0;
            walk_active      = 1'b0;
            lines_done       = '0;
            line_bytes_left  = '0;
            memory_cursor    = '0;
            device_cursor    = '0;
            memory_line_base = '0;
            device_line_base = '0;
            next_number      = '0;
            mismatches       = 0;
        endfunction

        function void set_register(psdw_reg_t which, logic [31:0] value);
            case (which)
                REG_LINES:      geometry.lines_in_transfer       = value[15:0];
                REG_BYTES:      geometry.bytes_per_line          = value[23:0];
                REG_MEM_START:  geometry.memory_start_offset     = value;
                REG_FB_START:   geometry.framebuffer_start       = value;
                REG_MEM_STRIDE: geometry.memory_line_stride      = value[23:0];
                REG_FB_STRIDE:  geometry.framebuffer_line_stride = value;
                default: ;
            endcase
        endfunction

        function void note_request(logic restart);
            psdw_desc_t  want;
            logic [31:0] room;
            logic [31:0] chunk;
            logic [31:0] page;
            want = '0;
            if (restart) begin
                lines_done       = '0;
                line_bytes_left  = geometry.bytes_per_line;
                memory_line_base = geometry.memory_start_offset;
                device_line_base = geometry.framebuffer_start;
                memory_cursor    = memory_line_base;
                device_cursor    = device_line_base;
                next_number      = '0;
                walk_active      = (geometry.lines_in_transfer != 0) &&
                                   (geometry.bytes_per_line != 0);
            end
            if (walk_active) begin
                room  = PAGE_BYTES - (memory_cursor % PAGE_BYTES);
                chunk = ({8'd0, line_bytes_left} < room) ? {8'd0, line_bytes_left} : room;
                page  = memory_cursor / PAGE_BYTES;
                want.page_index = page[19:0];
                page  = memory_cursor % PAGE_BYTES;
                want.page_offset       = page[11:0];
                want.device_address    = device_cursor;
                want.chunk_bytes       = chunk[12:0];
                want.descriptor_number = next_number;
                want.chunk_valid       = 1'b1;

                next_number     = next_number + 1;
                line_bytes_left = line_bytes_left - chunk[23:0];
                memory_cursor   = memory_cursor + chunk;
                device_cursor   = device_cursor + chunk;
                if (line_bytes_left == 0) begin
                    lines_done = lines_done + 16'd1;
                    if (lines_done == 0 || lines_done >= geometry.lines_in_transfer ||
                        geometry.bytes_per_line == 0) begin
                        walk_active = 1'b0;
                    end else begin
                        memory_line_base = memory_line_base + geometry.memory_line_stride;
                        device_line_base = device_line_base +
                                           geometry.framebuffer_line_stride;
                        memory_cursor    = memory_line_base;
                        device_cursor    = device_line_base;
                        line_bytes_left  = geometry.bytes_per_line;
                    end
                end
                want.final_chunk = !walk_active;
            end
            pending.push_back(want);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch: %s", what);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
        endtask

        task check_descriptor(psdw_desc_t got);
            psdw_desc_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("descriptor %0d arrived with no request waiting",
                                          got.descriptor_number));
                return;
            end
            want = pending.pop_front();
            compare_field("page_index", 32'(got.page_index), 32'(want.page_index));
            compare_field("page_offset", 32'(got.page_offset), 32'(want.page_offset));
            compare_field("device_address", got.device_address, want.device_address);
            compare_field("chunk_bytes", 32'(got.chunk_bytes), 32'(want.chunk_bytes));
            compare_field("descriptor_number", got.descriptor_number,
                          want.descriptor_number);
            compare_field("final_chunk", 32'(got.final_chunk), 32'(want.final_chunk));
            compare_field("chunk_valid", 32'(got.chunk_valid), 32'(want.chunk_valid));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_restart = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [19:0]           m_page_index;
    logic [11:0]           m_page_offset;
    logic [31:0]           m_device_address;
    logic [12:0]           m_chunk_bytes;
    logic [31:0]           m_descriptor_number;
    logic                  m_final_chunk;
    logic                  m_chunk_valid;

    descriptor_tracker tracker = new();
    int                requests_sent = 0;
    bit                steady = 1'b0;

    page_split_dma_descriptor_walker dut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 24);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            tracker.check_descriptor(psdw_desc_t'({m_page_index, m_page_offset,
                m_device_address, m_chunk_bytes, m_descriptor_number,
                m_final_chunk, m_chunk_valid}));
    end

    // Called at a falling edge; returns at a falling edge with the bus idle.
    task automatic write_reg(psdw_reg_t which, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(which) << 2;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_register(which, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(logic restart);
        int gap;
        steady = (requests_sent >= 300 && requests_sent < 450);
        gap = (!steady && $urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(restart);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic run_walk(int cap);
        int n;
        send_request(1'b1);
        for (n = 1; n < cap && tracker.walk_active; n++)
            send_request(1'b0);
    endtask

    // Holds the sender off until every outstanding descriptor has been taken.
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_value(psdw_reg_t which);
        int roll;
        roll = $urandom_range(0, 19);
        case (which)
            REG_LINES:
                return roll == 0 ? 32'd0 : roll == 1 ? 32'hFFFF :
                       roll == 2 ? $urandom : $urandom_range(1, 6);
            REG_BYTES:
                return roll == 0 ? 32'd0 : roll == 1 ? 32'hFF_FFFF :
                       roll == 2 ? $urandom :
                       roll < 6 ? 32'(PAGE_BYTES) * $urandom_range(1, 2) :
                       $urandom_range(1, 9000);
            REG_MEM_START:
                return roll == 0 ? 32'd0 : roll == 1 ? 32'hFFFF_FFFF :
                       roll < 6 ? ($urandom & ~32'(PAGE_BYTES - 1)) : $urandom;
            REG_MEM_STRIDE:
                return roll == 0 ? 32'd0 : roll == 1 ? 32'hFF_FFFF :
                       roll == 2 ? $urandom : ($urandom & 32'hFF_FFFF);
            default:
                return roll == 0 ? 32'd0 : roll == 1 ? 32'hFFFF_FFFF : $urandom;
        endcase
    endfunction

    initial begin
        psdw_reg_t which;
        int        n;

        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Nothing configured: both an advance and a restart find an empty walk.
        send_request(1'b0);
        send_request(1'b1);
        drain();

        // System side wraps past the top of the address space and crosses pages;
        // both strides are at their largest so the line bases wrap too.
        write_reg(REG_LINES, 32'd3);
        write_reg(REG_BYTES, 32'd5000);
        write_reg(REG_MEM_START, 32'hFFFF_FFA0);
        write_reg(REG_FB_START, 32'hFFFF_FFF0);
        write_reg(REG_MEM_STRIDE, 32'hFF_FFFF);
        write_reg(REG_FB_STRIDE, 32'hFFFF_FFFF);
        run_walk(40);
        send_request(1'b0);
        drain();

        // Page-aligned whole-page lines, then the line count cut short mid-walk.
        write_reg(REG_LINES, 32'd4);
        write_reg(REG_BYTES, 32'(PAGE_BYTES));
        write_reg(REG_MEM_START, 32'd0);
        write_reg(REG_FB_START, 32'h1000);
        write_reg(REG_MEM_STRIDE, 32'h2000);
        write_reg(REG_FB_STRIDE, 32'h2000);
        send_request(1'b1);
        send_request(1'b0);
        drain();
        write_reg(REG_LINES, 32'd1);
        send_request(1'b0);
        send_request(1'b0);
        drain();

        // A zero line length written mid-walk ends the walk at the line reload.
        write_reg(REG_LINES, 32'd4);
        send_request(1'b1);
        drain();
        write_reg(REG_BYTES, 32'd0);
        send_request(1'b0);
        send_request(1'b0);
        drain();

        // Largest geometry, including a restart while the walk is still going.
        write_reg(REG_LINES, 32'hFFFF);
        write_reg(REG_BYTES, 32'hFF_FFFF);
        write_reg(REG_MEM_STRIDE, 32'hFF_FFFF);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain();

        while (requests_sent < 830) begin
            for (n = 0; n < 6; n++) begin
                which = psdw_reg_t'(n);
                write_reg(which, pick_value(which));
            end
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 5)) send_request($urandom_range(0, 1));
                end else begin
                    run_walk(40);
                    repeat ($urandom_range(0, 2)) send_request(1'b0);
                end
            end
            // Registers are read live, so change one part-way through a walk.
            if ($urandom_range(0, 3) == 0) begin
                send_request(1'b1);
                repeat ($urandom_range(0, 3)) send_request(1'b0);
                drain();
                which = psdw_reg_t'($urandom_range(0, 5));
                write_reg(which, pick_value(which));
                for (n = 0; n < 20 && tracker.walk_active; n++)
                    send_request(1'b0);
                send_request(1'b0);
            end
            drain();
        end

        drain();
        repeat (4) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
